/* rtl/lld_pkg.sv */
// Shared types and constants for the least-loaded worker dispatcher.
// Holds payload structs, operation and state codes; depends on nothing.
`default_nettype none

package lld_pkg;

   // Field widths fixed by the interface
   localparam int KIND_W     = 3;
   localparam int IDX_W      = 4;
   localparam int COUNT_W    = 16;
   localparam int TIME_W     = 48;
   localparam int ACT_W      = 5;
   localparam int CORE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int US_W       = 20;
   localparam int LIMIT_US_W = COUNT_W + 1 + US_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
   localparam logic [US_W-1:0]    US_PER_SECOND    = 20'd1000000;
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET  = 16'd8;
   localparam logic [COUNT_W-1:0] IDLE_LIMIT_RESET = 16'd60;
   localparam logic [CORE_W-1:0]  CORE_RESET       = 5'd4;
   localparam logic [CORE_W-1:0]  CORE_MIN         = 5'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_AUTO     = 3'd0,
      KIND_FIXED    = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_IDLE     = 3'd3,
      KIND_COOLDOWN = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_IDLE_LIMIT = 2'd1,
      CSR_CORE       = 2'd2
   } csr_index_type;

   // Update applied by the selected cell
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_GIVE   = 3'd1,
      OP_ADD    = 3'd2,
      OP_TAKE   = 3'd3,
      OP_RETIRE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DECIDE = 2'd2,
      ST_APPLY  = 2'd3
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [IDX_W-1:0]   worker_index;
      logic [COUNT_W-1:0] request_count;
      logic [TIME_W-1:0]  now_us;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] chosen_worker;
      logic             scaled_up;
      logic             scaled_down;
      logic [ACT_W-1:0] active_workers;
      logic             status;
   } rsp_type;

   // Running scan summary handed from cell to cell
   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] best;
      logic               any_below;
      logic [COUNT_W-1:0] last_count;
      logic               last_mark;
      logic [TIME_W-1:0]  last_since;
   } scan_rec_type;

   typedef struct packed {
      op_type             op;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  now;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/lld_cell.sv */
// One worker cell: in-flight count, idle mark and idle time of one worker.
// Folds its worker into the scan summary each cycle; uses lld_pkg.
`default_nettype none

module lld_cell
   import lld_pkg::*;
#(
   parameter int MAX_WORKERS      = 16,
   parameter int RESERVED_WORKERS = 2,
   parameter int CELL_ID          = 0,
   localparam int IW = $clog2(MAX_WORKERS),
   localparam int TW = $clog2(MAX_WORKERS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               sel,
   input  wire cmd_type            cmd,
   input  wire logic [TW-1:0]      total,
   input  wire logic               extra,
   input  wire logic [COUNT_W-1:0] threshold,
   input  wire scan_rec_type       rec_in,
   input  wire logic [IW-1:0]      best_idx_in,
   output scan_rec_type            rec_out,
   output logic [IW-1:0]           best_idx_out
);

   localparam logic [TW-1:0] ID_T    = TW'(CELL_ID);
   localparam logic [IW-1:0] ID_I    = IW'(CELL_ID);
   localparam logic          GENERAL = (CELL_ID >= RESERVED_WORKERS);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               mark_ff, mark_in;
   logic [TIME_W-1:0]  since_ff, since_in;
   scan_rec_type       rec_ff, rec_in_next;
   logic [IW-1:0]      bidx_ff, bidx_in;

   logic               in_range;
   logic               is_last;
   logic               in_pick;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] sat;
   logic [COUNT_W-1:0] diff;

   // Role of this worker in the current scan
   assign in_range = (ID_T < total);
   assign is_last  = (ID_T == TW'(total - 1'b1));
   assign in_pick  = GENERAL && in_range && !(extra && is_last);

   // Fold this worker into the running summary
   always_comb begin
      rec_in_next = rec_in;
      bidx_in     = best_idx_in;
      if (in_pick && (!rec_in.found || (count_ff < rec_in.best))) begin
         rec_in_next.best = count_ff;
         bidx_in          = ID_I;
      end
      rec_in_next.found = rec_in.found | in_pick;
      if (GENERAL && in_range && (count_ff < threshold)) begin
         rec_in_next.any_below = 1'b1;
      end
      if (is_last) begin
         rec_in_next.last_count = count_ff;
         rec_in_next.last_mark  = mark_ff;
         rec_in_next.last_since = since_ff;
      end
   end

   // Apply the update command when selected
   always_comb begin
      sum      = {1'b0, count_ff} + {1'b0, cmd.count};
      sat      = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      diff     = (count_ff > cmd.count) ? (count_ff - cmd.count) : '0;
      count_in = count_ff;
      mark_in  = mark_ff;
      since_in = since_ff;
      if (sel) begin
         case (cmd.op)
            OP_GIVE: begin
               count_in = sat;
               mark_in  = (sat == '0);
               if (sat == '0) begin
                  since_in = cmd.now;
               end
            end
            OP_ADD: begin
               count_in = cmd.count;
               mark_in  = (cmd.count == '0);
               since_in = (cmd.count == '0) ? cmd.now : '0;
            end
            OP_TAKE: begin
               count_in = diff;
               if ((diff == '0) && !mark_ff) begin
                  mark_in  = 1'b1;
                  since_in = cmd.now;
               end
            end
            OP_RETIRE: begin
               mark_in  = 1'b0;
               since_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // Hold worker state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mark_ff  <= 1'b0;
         since_ff <= '0;
      end else begin
         count_ff <= count_in;
         mark_ff  <= mark_in;
         since_ff <= since_in;
      end
   end

   // Advance the summary to the next cell
   always_ff @(posedge clock) begin
      rec_ff  <= rec_in_next;
      bidx_ff <= bidx_in;
   end

   assign rec_out      = rec_ff;
   assign best_idx_out = bidx_ff;

endmodule

`default_nettype wire

/* rtl/lld_ctrl.sv */
// Dispatcher control: handshakes, configuration registers, worker total
// and the decision taken from the end of the cell row; uses lld_pkg.
`default_nettype none

module lld_ctrl
   import lld_pkg::*;
#(
   parameter int MAX_WORKERS = 16,
   localparam int IW = $clog2(MAX_WORKERS),
   localparam int TW = $clog2(MAX_WORKERS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire scan_rec_type          tail_rec,
   input  wire logic [IW-1:0]         tail_best_idx,
   output logic [TW-1:0]              total,
   output logic                       extra,
   output logic [COUNT_W-1:0]         threshold,
   output cmd_type                    cmd,
   output logic [MAX_WORKERS-1:0]     sel
);

   localparam logic [TW-1:0] MAX_T  = TW'(MAX_WORKERS);
   localparam logic [IW-1:0] LAST_C = IW'(MAX_WORKERS - 1);

   state_type             state_ff, state_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   req_type               item_ff;
   logic [TW-1:0]         total_ff, total_in;
   logic                  allowed_ff, allowed_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IW-1:0]         tgt_ff, tgt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]    thr_ff;
   logic [COUNT_W-1:0]    limit_ff;
   logic [CORE_W-1:0]     core_ff;
   logic [LIMIT_US_W-1:0] limit_us_ff, limit_us_in;

   logic [TW-1:0]         core_num;
   logic                  go;
   logic                  idx_ok;
   logic [IW-1:0]         last_idx;
   logic                  can_up;
   logic [IW-1:0]         pick;
   logic                  idle_ok;
   logic [TIME_W:0]       expire;
   op_type                dec_op;
   logic [IW-1:0]         dec_tgt;
   logic [IW-1:0]         dec_chosen;
   logic                  dec_up;
   logic                  dec_down;
   logic                  dec_status;
   logic [TW-1:0]         dec_total;
   logic                  dec_allowed;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         limit_ff <= IDLE_LIMIT_RESET;
         core_ff  <= CORE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD:  thr_ff   <= csr_wdata;
            CSR_IDLE_LIMIT: limit_ff <= csr_wdata;
            CSR_CORE:       core_ff  <= csr_wdata[CORE_W-1:0];
            default:        thr_ff   <= thr_ff;
         endcase
      end
   end

   // Idle limit in microseconds, one whole second past the limit
   assign limit_us_in = LIMIT_US_W'({1'b0, limit_ff} + 1'b1) *
                        LIMIT_US_W'(US_PER_SECOND);

   always_ff @(posedge clock) begin
      limit_us_ff <= limit_us_in;
   end

   // Clamp the core count to its legal range
   always_comb begin
      if (core_ff < CORE_MIN) begin
         core_num = TW'(CORE_MIN);
      end else if (core_ff > MAX_WORKERS) begin
         core_num = MAX_T;
      end else begin
         core_num = TW'(core_ff);
      end
   end

   assign extra     = (total_ff > core_num);
   assign total     = total_ff;
   assign threshold = thr_ff;

   // Decide the update from the scan summary
   always_comb begin
      idx_ok   = (TW'(item_ff.worker_index) < total_ff);
      last_idx = IW'(total_ff - 1'b1);
      can_up   = allowed_ff && (total_ff < MAX_T) &&
                 ((total_ff < core_num) || !tail_rec.any_below);
      if ((tail_rec.found && (tail_rec.best < thr_ff)) || !extra) begin
         pick = tail_best_idx;
      end else if (!tail_rec.found || (tail_rec.last_count < tail_rec.best)) begin
         pick = last_idx;
      end else begin
         pick = tail_best_idx;
      end
      expire  = {1'b0, tail_rec.last_since} + (TIME_W + 1)'(limit_us_ff);
      idle_ok = allowed_ff && extra && tail_rec.last_mark &&
                (tail_rec.last_count == '0) && ({1'b0, item_ff.now_us} >= expire);

      dec_op      = OP_NONE;
      dec_tgt     = '0;
      dec_chosen  = '0;
      dec_up      = 1'b0;
      dec_down    = 1'b0;
      dec_status  = 1'b0;
      dec_total   = total_ff;
      dec_allowed = allowed_ff;
      case (item_ff.kind)
         KIND_AUTO: begin
            if (can_up) begin
               dec_op      = OP_ADD;
               dec_tgt     = IW'(total_ff);
               dec_chosen  = IW'(total_ff);
               dec_up      = 1'b1;
               dec_total   = TW'(total_ff + 1'b1);
               dec_allowed = 1'b0;
            end else begin
               dec_op     = OP_GIVE;
               dec_tgt    = pick;
               dec_chosen = pick;
            end
         end
         KIND_FIXED: begin
            if (idx_ok) begin
               dec_op     = OP_GIVE;
               dec_tgt    = IW'(item_ff.worker_index);
               dec_chosen = IW'(item_ff.worker_index);
            end else begin
               dec_status = 1'b1;
            end
         end
         KIND_DONE: begin
            if (idx_ok) begin
               dec_op  = OP_TAKE;
               dec_tgt = IW'(item_ff.worker_index);
            end else begin
               dec_status = 1'b1;
            end
         end
         KIND_IDLE: begin
            if (idle_ok) begin
               dec_op    = OP_RETIRE;
               dec_tgt   = last_idx;
               dec_down  = 1'b1;
               dec_total = TW'(total_ff - 1'b1);
            end
         end
         KIND_COOLDOWN: begin
            dec_allowed = 1'b1;
         end
         default: begin
            dec_op = OP_NONE;
         end
      endcase
   end

   // Next state, handshakes and register loads
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      go           = 1'b0;
      total_in     = total_ff;
      allowed_in   = allowed_ff;
      cmd_in       = cmd_ff;
      tgt_in       = tgt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = IW'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_C) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               go       = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (go) begin
         total_in                   = dec_total;
         allowed_in                 = dec_allowed;
         cmd_in.op                  = dec_op;
         cmd_in.count               = item_ff.request_count;
         cmd_in.now                 = item_ff.now_us;
         tgt_in                     = dec_tgt;
         rsp_valid_in               = 1'b1;
         rsp_data_in.chosen_worker  = IDX_W'(dec_chosen);
         rsp_data_in.scaled_up      = dec_up;
         rsp_data_in.scaled_down    = dec_down;
         rsp_data_in.active_workers = ACT_W'(dec_total);
         rsp_data_in.status         = dec_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         total_ff     <= TW'(CORE_RESET);
         allowed_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         allowed_ff   <= allowed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the command only acts while a cell is selected
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      cmd_ff      <= cmd_in;
      tgt_ff      <= tgt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Select the target cell during the update cycle
   always_comb begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
         sel[i] = (state_ff == ST_APPLY) && (tgt_ff == IW'(i));
      end
   end

   assign cmd       = cmd_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      (total_ff <= MAX_T) && (total_ff >= TW'(CORE_MIN)))
      else $error("worker total out of range");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_ff != $past(total_ff)) |-> ($past(state_ff) == ST_DECIDE))
      else $error("worker total changed outside a decision");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("decision did not present a result");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.scaled_up && rsp_data_ff.scaled_down))
      else $error("scale up and scale down in one result");

   a_sel: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel))
      else $error("more than one cell selected");
`endif

endmodule

`default_nettype wire

/* rtl/least_loaded_worker_dispatcher.sv */
// Top level of the least-loaded worker dispatcher: a row of worker cells
// and the control block. Depends on lld_pkg, lld_cell and lld_ctrl.
//
// The dispatcher accepts one item at a time and takes no new item until
// the last one has passed the scan, decide and apply states: the scan
// summary crosses the row of worker cells at one cell per cycle, then the
// decide state picks the update and the apply state writes it into the
// chosen cell. The result is registered when the decision is taken and
// is held in an output register, so a waiting result stalls the block
// only when the next decision is ready. No clearing pass follows reset.
`default_nettype none

module least_loaded_worker_dispatcher
   import lld_pkg::*;
#(
   parameter int MAX_WORKERS      = 16,
   parameter int RESERVED_WORKERS = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = $clog2(MAX_WORKERS);
   localparam int TW = $clog2(MAX_WORKERS + 1);

   scan_rec_type           chain_rec  [MAX_WORKERS+1];
   logic [IW-1:0]          chain_bidx [MAX_WORKERS+1];
   logic [TW-1:0]          total;
   logic                   extra;
   logic [COUNT_W-1:0]     threshold;
   cmd_type                cmd;
   logic [MAX_WORKERS-1:0] sel;

   // Start every scan from an empty summary
   assign chain_rec[0]  = '0;
   assign chain_bidx[0] = '0;

   // Row of worker cells
   for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
      lld_cell #(
         .MAX_WORKERS      (MAX_WORKERS),
         .RESERVED_WORKERS (RESERVED_WORKERS),
         .CELL_ID          (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .sel          (sel[g]),
         .cmd          (cmd),
         .total        (total),
         .extra        (extra),
         .threshold    (threshold),
         .rec_in       (chain_rec[g]),
         .best_idx_in  (chain_bidx[g]),
         .rec_out      (chain_rec[g+1]),
         .best_idx_out (chain_bidx[g+1])
      );
   end

   lld_ctrl #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .tail_rec      (chain_rec[MAX_WORKERS]),
      .tail_best_idx (chain_bidx[MAX_WORKERS]),
      .total         (total),
      .extra         (extra),
      .threshold     (threshold),
      .cmd           (cmd),
      .sel           (sel)
   );

endmodule

`default_nettype wire
